/* rtl/core/rsmd_pkg.sv */
package rsmd_pkg;

   localparam int KEY_BYTES_DEF = 16;
   localparam int ADDR_BITS_DEF = 32;

   localparam int KEY_W = 128;
   localparam int LEN_W = 5;
   localparam int PPA_W = 32;

   localparam int REQ_TDATA_W = 168;
   localparam int RSP_TDATA_W = 168;

   localparam logic SIDE_OLDER = 1'b0;
   localparam logic SIDE_NEWER = 1'b1;

   typedef enum logic [1:0] {
      KIND_ENTRY = 2'd0,
      KIND_INVAL = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      NEED_OLDER = 2'd0,
      NEED_NEWER = 2'd1,
      NEED_NONE  = 2'd2
   } need_type;

   // One input beat, key as {key_high, key_low} with byte 0 on top.
   typedef struct packed {
      logic             side;
      logic             is_end;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [PPA_W-1:0] ppa;
   } item_type;

   // Everything one step produces: the main result and, on equal keys,
   // the invalidated older address that goes out first.
   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [PPA_W-1:0] ppa;
      logic             dup;
      logic [PPA_W-1:0] dup_ppa;
      need_type         need;
   } step_type;

   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [PPA_W-1:0] ppa;
      need_type         need;
      logic             last;
   } beat_type;

   // Keep the first len bytes of a top-aligned key.
   function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < KEY_W / 8; i++) begin
         if (LEN_W'(i) < len) begin
            m[KEY_W-1-8*i -: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

/* rtl/core/sorted_run_merge_dedup.sv */
// Two-way merge with duplicate removal for LSM compaction. Feed key entries on
// the req channel, each marked for the older (tuser 0) or newer (tuser 1) run,
// with tlast marking the end of that run instead of an entry. Every request beat
// yields one step of results on rsp: a merged entry, an invalidated older
// address followed by the newer entry when keys are equal, a completion marker
// once both runs have ended, or a bare acknowledge when nothing can go out yet.
// Every result names the side to feed next; rsp_tlast marks the final beat of a
// step. Keys are compared bytewise over the common prefix, shorter first; bytes
// past key_len are zeroed, key_len saturates at KEY_BYTES and ppa keeps
// ADDR_BITS bits. One request beat is taken per clock while the result queue
// has room; a step with equal keys occupies the rsp channel for two beats. A
// request passes one input register, then a compare-and-select stage that
// writes into a two-step result queue; the queue lets requests keep flowing
// while a result waits to be taken. After completion, reset starts a new
// merge.
module sorted_run_merge_dedup
   import rsmd_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // key_high[63:0], key_low[127:64], key_len[132:128], ppa[164:133], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // side
   input  logic                   req_tuser,
   // is_end
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_key_high[63:0], out_key_low[127:64], out_key_len[132:128],
   // out_ppa[164:133], need_side[166:165], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // kind
   output logic [1:0]             rsp_tuser,
   // last
   output logic                   rsp_tlast
);

   item_type item;
   step_type step;
   logic     step_valid, step_ready;
   beat_type beat;

   // unpack the request beat; key_high holds the leading bytes
   assign item.side   = req_tuser;
   assign item.is_end = req_tlast;
   assign item.key    = {req_tdata[63:0], req_tdata[127:64]};
   assign item.len    = req_tdata[132:128];
   assign item.ppa    = req_tdata[164:133];

   rsmd_merge_core #(
      .KEY_BYTES(KEY_BYTES),
      .ADDR_BITS(ADDR_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (item),
      .step_valid(step_valid),
      .step      (step),
      .step_ready(step_ready)
   );

   rsmd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(step_valid),
      .push_ready(step_ready),
      .push_step (step),
      .beat_valid(rsp_tvalid),
      .beat_ready(rsp_tready),
      .beat      (beat)
   );

   // pack the result beat
   assign rsp_tdata = {1'b0, beat.need, beat.ppa, beat.len,
                       beat.key[KEY_W/2-1:0], beat.key[KEY_W-1:KEY_W/2]};
   assign rsp_tuser = beat.kind;
   assign rsp_tlast = beat.last;

endmodule

/* rtl/core/rsmd_key_cmp.sv */
module rsmd_key_cmp
   import rsmd_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic [8*KEY_BYTES-1:0] a_key,
   input  logic [LEN_W-1:0]       a_len,
   input  logic [8*KEY_BYTES-1:0] b_key,
   input  logic [LEN_W-1:0]       b_len,
   output logic                   a_lt,
   output logic                   a_eq
);

   localparam int KEY_BITS = 8 * KEY_BYTES;

   logic [LEN_W-1:0]    min_len;
   logic [KEY_W-1:0]    full_mask;
   logic [KEY_BITS-1:0] a_cut;
   logic [KEY_BITS-1:0] b_cut;
   logic                pre_eq;

   // Compare only the common prefix; keys are zero beyond their length.
   assign min_len   = (a_len < b_len) ? a_len : b_len;
   assign full_mask = byte_mask(min_len);
   assign a_cut     = a_key & full_mask[KEY_W-1 -: KEY_BITS];
   assign b_cut     = b_key & full_mask[KEY_W-1 -: KEY_BITS];
   assign pre_eq    = (a_cut == b_cut);

   assign a_lt = (a_cut < b_cut) || (pre_eq && (a_len < b_len));
   assign a_eq = pre_eq && (a_len == b_len);

endmodule

/* rtl/core/rsmd_merge_core.sv */
module rsmd_merge_core
   import rsmd_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     step_valid,
   output step_type step,
   input  logic     step_ready
);

   localparam int KEY_BITS = 8 * KEY_BYTES;
   localparam int ADDR_W   = (ADDR_BITS < PPA_W) ? ADDR_BITS : PPA_W;

   // input conditioning
   logic [LEN_W-1:0] len_sat;
   logic [KEY_W-1:0] key_msk;

   logic                in_vld_ff;
   logic                in_side_ff;
   logic                in_end_ff;
   logic [KEY_BITS-1:0] in_key_ff;
   logic [LEN_W-1:0]    in_len_ff;
   logic [ADDR_W-1:0]   in_addr_ff;

   logic                o_valid_ff, o_drained_ff, n_valid_ff, n_drained_ff;
   logic [KEY_BITS-1:0] o_key_ff, n_key_ff;
   logic [LEN_W-1:0]    o_len_ff, n_len_ff;
   logic [ADDR_W-1:0]   o_addr_ff, n_addr_ff;

   logic                fire, acc, take_o, take_n, end_o, end_n;
   logic                o_valid_mid, o_drained_mid, n_valid_mid, n_drained_mid;
   logic [KEY_BITS-1:0] o_key_in, n_key_in;
   logic [LEN_W-1:0]    o_len_in, n_len_in;
   logic [ADDR_W-1:0]   o_addr_in, n_addr_in;
   logic                o_valid_in, n_valid_in, o_drained_in, n_drained_in;
   logic                o_lt, o_eq, emit, pick_o, pick_n, cons_o, cons_n;
   logic [KEY_W-1:0]    o_key_wide, n_key_wide;

   assign len_sat = (in_item.len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_item.len;
   assign key_msk = in_item.key & byte_mask(len_sat);

   assign fire       = in_vld_ff && step_ready;
   assign in_ready   = !in_vld_ff || step_ready;
   assign step_valid = in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_ready) begin
         in_vld_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         in_side_ff <= in_item.side;
         in_end_ff  <= in_item.is_end;
         in_key_ff  <= key_msk[KEY_W-1 -: KEY_BITS];
         in_len_ff  <= len_sat;
         in_addr_ff <= in_item.ppa[ADDR_W-1:0];
      end
   end

   // A side takes a beat only when it has neither a head nor an end mark.
   assign acc    = (in_side_ff == SIDE_NEWER) ? (!n_valid_ff && !n_drained_ff)
                                              : (!o_valid_ff && !o_drained_ff);
   assign take_o = acc && (in_side_ff == SIDE_OLDER) && !in_end_ff;
   assign take_n = acc && (in_side_ff == SIDE_NEWER) && !in_end_ff;
   assign end_o  = acc && (in_side_ff == SIDE_OLDER) && in_end_ff;
   assign end_n  = acc && (in_side_ff == SIDE_NEWER) && in_end_ff;

   assign o_valid_mid   = o_valid_ff | take_o;
   assign n_valid_mid   = n_valid_ff | take_n;
   assign o_drained_mid = o_drained_ff | end_o;
   assign n_drained_mid = n_drained_ff | end_n;

   assign o_key_in  = take_o ? in_key_ff  : o_key_ff;
   assign o_len_in  = take_o ? in_len_ff  : o_len_ff;
   assign o_addr_in = take_o ? in_addr_ff : o_addr_ff;
   assign n_key_in  = take_n ? in_key_ff  : n_key_ff;
   assign n_len_in  = take_n ? in_len_ff  : n_len_ff;
   assign n_addr_in = take_n ? in_addr_ff : n_addr_ff;

   rsmd_key_cmp #(
      .KEY_BYTES(KEY_BYTES)
   ) u_cmp (
      .a_key(o_key_in),
      .a_len(o_len_in),
      .b_key(n_key_in),
      .b_len(n_len_in),
      .a_lt (o_lt),
      .a_eq (o_eq)
   );

   assign emit = acc && (o_valid_mid || o_drained_mid) && (n_valid_mid || n_drained_mid);

   always_comb begin
      o_key_wide = '0;
      n_key_wide = '0;
      o_key_wide[KEY_W-1 -: KEY_BITS] = o_key_in;
      n_key_wide[KEY_W-1 -: KEY_BITS] = n_key_in;
   end

   always_comb begin
      pick_o = 1'b0;
      pick_n = 1'b0;
      cons_o = 1'b0;
      cons_n = 1'b0;
      step.kind    = KIND_ACK;
      step.key     = '0;
      step.len     = '0;
      step.ppa     = '0;
      step.dup     = 1'b0;
      step.dup_ppa = PPA_W'(o_addr_in);
      if (emit) begin
         priority if (o_valid_mid && n_valid_mid) begin
            if (o_eq) begin
               pick_n   = 1'b1;
               cons_o   = 1'b1;
               step.dup = 1'b1;
            end else if (o_lt) begin
               pick_o = 1'b1;
            end else begin
               pick_n = 1'b1;
            end
         end else if (o_valid_mid) begin
            pick_o = 1'b1;
         end else if (n_valid_mid) begin
            pick_n = 1'b1;
         end else begin
            step.kind = KIND_DONE;
         end
      end
      if (pick_o) begin
         cons_o    = 1'b1;
         step.kind = KIND_ENTRY;
         step.key  = o_key_wide;
         step.len  = o_len_in;
         step.ppa  = PPA_W'(o_addr_in);
      end
      if (pick_n) begin
         cons_n    = 1'b1;
         step.kind = KIND_ENTRY;
         step.key  = n_key_wide;
         step.len  = n_len_in;
         step.ppa  = PPA_W'(n_addr_in);
      end
      // ask for the older side first, then the newer one, from the heads left after this step
      priority if (!(o_valid_mid && !cons_o) && !o_drained_mid) begin
         step.need = NEED_OLDER;
      end else if (!(n_valid_mid && !cons_n) && !n_drained_mid) begin
         step.need = NEED_NEWER;
      end else begin
         step.need = NEED_NONE;
      end
   end

   assign o_valid_in   = o_valid_mid && !cons_o;
   assign n_valid_in   = n_valid_mid && !cons_n;
   assign o_drained_in = o_drained_mid;
   assign n_drained_in = n_drained_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff   <= 1'b0;
         o_drained_ff <= 1'b0;
         n_valid_ff   <= 1'b0;
         n_drained_ff <= 1'b0;
      end else if (fire) begin
         o_valid_ff   <= o_valid_in;
         o_drained_ff <= o_drained_in;
         n_valid_ff   <= n_valid_in;
         n_drained_ff <= n_drained_in;
      end
      if (fire) begin
         o_key_ff  <= o_key_in;
         o_len_ff  <= o_len_in;
         o_addr_ff <= o_addr_in;
         n_key_ff  <= n_key_in;
         n_len_ff  <= n_len_in;
         n_addr_ff <= n_addr_in;
      end
   end

   a_no_two_heads: assert property (@(posedge clock) disable iff (reset)
      !(o_valid_ff && n_valid_ff))
      else $error("both heads held after a step");

   a_head_or_end: assert property (@(posedge clock) disable iff (reset)
      !(o_valid_ff && o_drained_ff) && !(n_valid_ff && n_drained_ff))
      else $error("side holds a head after its end mark");

   a_drain_sticks: assert property (@(posedge clock) disable iff (reset)
      (o_drained_ff && n_drained_ff) |=> (o_drained_ff && n_drained_ff))
      else $error("completed merge left the drained state");

endmodule

/* rtl/core/rsmd_rsp_queue.sv */
module rsmd_rsp_queue
   import rsmd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  step_type push_step,
   output logic     beat_valid,
   input  logic     beat_ready,
   output beat_type beat
);

   step_type   q0_ff, q1_ff, q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       phase_ff, phase_in;
   logic       push, pop_beat, pop_step;

   assign push_ready = (cnt_ff != 2'd2);
   assign push       = push_valid && push_ready;
   assign beat_valid = (cnt_ff != 2'd0);
   assign pop_beat   = beat_valid && beat_ready;
   assign pop_step   = pop_beat && (!q0_ff.dup || phase_ff);

   // On equal keys send the invalidated older address first.
   always_comb begin
      beat.need = q0_ff.need;
      if (q0_ff.dup && !phase_ff) begin
         beat.kind = KIND_INVAL;
         beat.key  = '0;
         beat.len  = '0;
         beat.ppa  = q0_ff.dup_ppa;
         beat.last = 1'b0;
      end else begin
         beat.kind = q0_ff.kind;
         beat.key  = q0_ff.key;
         beat.len  = q0_ff.len;
         beat.ppa  = q0_ff.ppa;
         beat.last = 1'b1;
      end
   end

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      unique case ({push, pop_step})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               q0_in = push_step;
            end else begin
               q1_in = push_step;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            q0_in  = q1_ff;
            cnt_in = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               q0_in = push_step;
            end else begin
               q0_in = q1_ff;
               q1_in = push_step;
            end
         end
         default: begin
         end
      endcase
      if (pop_step) begin
         phase_in = 1'b0;
      end else if (pop_beat) begin
         phase_in = 1'b1;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         phase_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("step queue overflow");

   a_phase_dup: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (cnt_ff != 2'd0) && q0_ff.dup)
      else $error("second beat pending without a duplicate step");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import rsmd_pkg::*;

   localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
   localparam int RUN_KEYS    = 1200;  // distinct keys spread over the two runs
   localparam int TAIL_BEATS  = 10;    // beats sent after the merge completed

   // Heads held for the older and the newer run, plus their end marks.
   typedef struct packed {
      logic         o_valid;
      logic         o_drained;
      logic [127:0] o_key;
      logic [4:0]   o_len;
      logic [31:0]  o_ppa;
      logic         n_valid;
      logic         n_drained;
      logic [127:0] n_key;
      logic [4:0]   n_len;
      logic [31:0]  n_ppa;
   } heads_type;

   // A key of the sorted list with its position in merge order.
   typedef struct packed {
      item_type     it;
      logic [132:0] ord;
   } run_key_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   item_type    script_q[$];   // whole request stream, built up front
   item_type    entry_q[$];    // request beats released to the driver
   beat_type    due_q[$];      // results still owed by the block
   run_key_type key_list[$];   // distinct keys in merge order
   item_type    older_run[$];
   item_type    newer_run[$];

   heads_type plan_heads;      // heads as the stream builder sees them
   heads_type mirror_heads;    // heads as of the last accepted beat
   need_type  plan_need;
   item_type  cur_req;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int n_err   = 0;
   int n_req   = 0;
   int n_entry = 0;
   int n_inval = 0;
   int n_done  = 0;
   int n_ack   = 0;

   sorted_run_merge_dedup uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   task automatic report(input string what);
      n_err++;
      if (n_err <= 40) begin
         $display("tb: MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // Saturate an oversized key length.
   function automatic logic [4:0] clamp_len(input logic [4:0] n);
      return (n > KEY_BYTES_DEF) ? 5'(KEY_BYTES_DEF) : n;
   endfunction

   // Top-aligned mask that keeps the first n bytes; n of zero keeps nothing.
   function automatic logic [127:0] byte_keep(input logic [4:0] n);
      return ~128'd0 << (8 * (16 - int'(n)));
   endfunction

   // Merge order: comparing the zero padded bytes and then the length is the
   // same as comparing the common prefix bytewise with the shorter key first.
   function automatic logic [132:0] merge_order(input item_type it);
      logic [4:0] n;
      n = clamp_len(it.len);
      return {it.key & byte_keep(n), n};
   endfunction

   // Advance the heads by one request beat and return the results it causes
   // (one or two, r0 goes out first).
   function automatic int merge_step(inout heads_type h, input item_type it,
                                     output beat_type r0, output beat_type r1);
      logic [4:0]   n;
      logic         taken;
      logic [132:0] ord_o;
      logic [132:0] ord_n;
      need_type     need;
      int           cnt;
      n   = clamp_len(it.len);
      r0  = '0;
      r1  = '0;
      cnt = 0;
      taken = (it.side == SIDE_NEWER) ? (!h.n_valid && !h.n_drained)
                                      : (!h.o_valid && !h.o_drained);
      // Take the beat only on a side that has neither a head nor an end mark.
      if (taken) begin
         if (it.is_end) begin
            if (it.side == SIDE_NEWER) h.n_drained = 1'b1;
            else h.o_drained = 1'b1;
         end else if (it.side == SIDE_NEWER) begin
            h.n_valid = 1'b1;
            h.n_key   = it.key & byte_keep(n);
            h.n_len   = n;
            h.n_ppa   = it.ppa;
         end else begin
            h.o_valid = 1'b1;
            h.o_key   = it.key & byte_keep(n);
            h.o_len   = n;
            h.o_ppa   = it.ppa;
         end
      end
      if (taken && (h.o_valid || h.o_drained) && (h.n_valid || h.n_drained)) begin
         ord_o = {h.o_key, h.o_len};
         ord_n = {h.n_key, h.n_len};
         if (h.o_valid && (!h.n_valid || ord_o < ord_n)) begin
            r0.kind = KIND_ENTRY;
            r0.key  = h.o_key;
            r0.len  = h.o_len;
            r0.ppa  = h.o_ppa;
            h.o_valid = 1'b0;
            cnt = 1;
         end else if (h.n_valid && (!h.o_valid || ord_n < ord_o)) begin
            r0.kind = KIND_ENTRY;
            r0.key  = h.n_key;
            r0.len  = h.n_len;
            r0.ppa  = h.n_ppa;
            h.n_valid = 1'b0;
            cnt = 1;
         end else if (h.o_valid) begin
            // Equal keys: drop the older address first, then pass the newer entry.
            r0.kind = KIND_INVAL;
            r0.ppa  = h.o_ppa;
            r1.kind = KIND_ENTRY;
            r1.key  = h.n_key;
            r1.len  = h.n_len;
            r1.ppa  = h.n_ppa;
            h.o_valid = 1'b0;
            h.n_valid = 1'b0;
            cnt = 2;
         end else begin
            r0.kind = KIND_DONE;
            cnt = 1;
         end
      end
      if (cnt == 0) begin
         r0.kind = KIND_ACK;
         cnt = 1;
      end
      if (!h.o_valid && !h.o_drained) need = NEED_OLDER;
      else if (!h.n_valid && !h.n_drained) need = NEED_NEWER;
      else need = NEED_NONE;
      r0.need = need;
      r1.need = need;
      r0.last = (cnt == 1);
      r1.last = 1'b1;
      return cnt;
   endfunction

   function automatic item_type mk(input logic side, input logic is_end,
                                   input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [4:0] len, input logic [31:0] ppa);
      item_type it;
      it.side   = side;
      it.is_end = is_end;
      it.key    = {hi, lo};
      it.len    = len;
      it.ppa    = ppa;
      return it;
   endfunction

   function automatic item_type random_item();
      return mk(1'($urandom), 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                5'($urandom_range(31)), $urandom);
   endfunction

   // Bias key bytes toward the values where byte order is most likely to break.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h7F;
         3: return 8'h80;
         4: return 8'hFE;
         5: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // New run key: often a one-byte or length variant of an existing key, so
   // that heads share long prefixes.
   function automatic item_type make_key();
      item_type k;
      int       pos;
      int       r;
      k = '0;
      if (key_list.size() > 0 && $urandom_range(99) < 40) begin
         k   = key_list[$urandom_range(key_list.size() - 1)].it;
         pos = $urandom_range(15);
         k.key[127-8*pos -: 8] = pick_byte();
         if ($urandom_range(3) == 0) k.len = 5'($urandom_range(16, 1));
      end else begin
         for (pos = 0; pos < 16; pos++) k.key[127-8*pos -: 8] = pick_byte();
         r = $urandom_range(99);
         if (r < 3) k.len = 5'd0;
         else if (r < 6) k.len = 5'($urandom_range(31, 17));
         else k.len = 5'($urandom_range(16, 1));
      end
      // Leave junk past the key length on some keys.
      if ($urandom_range(99) < 70) k.key &= byte_keep(clamp_len(k.len));
      return k;
   endfunction

   function automatic logic [31:0] pick_ppa();
      case ($urandom_range(19))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Append a request beat to the stream and track where the merge stands.
   task automatic add(input item_type it);
      beat_type r0;
      beat_type r1;
      int       cnt;
      cnt = merge_step(plan_heads, it, r0, r1);
      plan_need = r0.need;
      script_q.push_back(it);
   endtask

   // Driver: present the next beat, hold it until taken, and on each accepted
   // beat queue the results the block owes for it.
   always @(posedge clock) begin : drive
      beat_type r0;
      beat_type r1;
      int       cnt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            cnt = merge_step(mirror_heads, cur_req, r0, r1);
            due_q.push_back(r0);
            if (cnt == 2) due_q.push_back(r1);
            n_req++;
         end
         if (!req_tvalid || req_tready) begin
            if (entry_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = entry_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, cur_req.ppa, cur_req.len,
                              cur_req.key[63:0], cur_req.key[127:64]};
               req_tuser  <= cur_req.side;
               req_tlast  <= cur_req.is_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every accepted result beat against the oldest one owed,
   // and stall the result side at random.
   always @(posedge clock) begin : watch
      beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_q.size() == 0) begin
               report($sformatf("result beat kind %0d with nothing owed", rsp_tuser));
            end else begin
               want = due_q.pop_front();
               if (rsp_tuser !== want.kind)
                  report($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
               if (rsp_tdata[63:0] !== want.key[127:64])
                  report($sformatf("key_high %h, want %h", rsp_tdata[63:0],
                                   want.key[127:64]));
               if (rsp_tdata[127:64] !== want.key[63:0])
                  report($sformatf("key_low %h, want %h", rsp_tdata[127:64],
                                   want.key[63:0]));
               if (rsp_tdata[132:128] !== want.len)
                  report($sformatf("key_len %0d, want %0d", rsp_tdata[132:128], want.len));
               if (rsp_tdata[164:133] !== want.ppa)
                  report($sformatf("ppa %h, want %h", rsp_tdata[164:133], want.ppa));
               if (rsp_tdata[166:165] !== want.need)
                  report($sformatf("need_side %0d, want %0d", rsp_tdata[166:165],
                                   want.need));
               if (rsp_tlast !== want.last)
                  report($sformatf("last %b, want %b", rsp_tlast, want.last));
            end
            case (rsp_tuser)
               KIND_ENTRY: n_entry++;
               KIND_INVAL: n_inval++;
               KIND_DONE:  n_done++;
               default:    n_ack++;
            endcase
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run if neither side moves for too long.
   always @(posedge clock) begin : dog
      int quiet;
      if (reset) begin
         quiet = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("tb: timeout, %0d results still owed", due_q.size());
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int          idle_tab[4];
      int          stall_tab[4];
      run_key_type rk;
      item_type    it;
      item_type    nz;
      int          pos;
      int          oi;
      int          ni;
      int          total;
      int          ph;
      logic        s;
      logic        open;
      idle_tab  = '{0, 50, 0, 38};
      stall_tab = '{0, 0, 50, 38};
      plan_heads   = '0;
      mirror_heads = '0;
      plan_need    = NEED_OLDER;

      // Directed opening.
      // Newer head before any older one: nothing can go out yet.
      add(mk(SIDE_NEWER, 1'b0, '1, '1, 5'd16, 32'hFFFF_FFFF));
      // Newer side already holds a head: drop this beat.
      add(mk(SIDE_NEWER, 1'b0, 64'h0123_4567_89AB_CDEF, '0, 5'd5, 32'h1111_1111));
      // Oversized length saturates to a full key equal to the newer head.
      add(mk(SIDE_OLDER, 1'b0, '1, '1, 5'd31, 32'h0000_0000));
      // Empty key sorts before a one-byte zero key.
      add(mk(SIDE_OLDER, 1'b0, '0, '0, 5'd0, 32'h0000_0001));
      add(mk(SIDE_NEWER, 1'b0, '0, '0, 5'd1, 32'h0000_0002));
      // Junk past the key length must not take part in the compare.
      add(mk(SIDE_OLDER, 1'b0, '1, '1, 5'd3, 32'h0000_0003));
      add(mk(SIDE_NEWER, 1'b0, 64'hFFFF_FFA5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
             5'd3, 32'hDEAD_BEEF));
      // Equal prefix: shorter key first.
      add(mk(SIDE_OLDER, 1'b0, 64'h4142_0000_0000_0000, '0, 5'd2, 32'h0000_0004));
      add(mk(SIDE_NEWER, 1'b0, 64'h4142_4300_0000_0000, '0, 5'd3, 32'h0000_0005));
      // Bytes compare unsigned: 0x7F before 0x80.
      add(mk(SIDE_OLDER, 1'b0, 64'h8000_0000_0000_0000, '0, 5'd1, 32'h0000_0006));
      add(mk(SIDE_NEWER, 1'b0, 64'h7F00_0000_0000_0000, '0, 5'd1, 32'h0000_0007));
      // Keys that differ only in the low word.
      add(mk(SIDE_NEWER, 1'b0, 64'h8000_0000_0000_0000, 64'h9900_0000_0000_0000,
             5'd9, 32'h0000_0008));
      add(mk(SIDE_OLDER, 1'b0, 64'h8000_0000_0000_0000, 64'h9A00_0000_0000_0000,
             5'd9, 32'h0000_0009));
      add(mk(SIDE_NEWER, 1'b0, 64'h8000_0000_0000_0000, 64'h9AFF_FFFF_FFFF_FFFF,
             5'd16, 32'h0000_000A));
      add(mk(SIDE_OLDER, 1'b0, '0, '0, 5'd16, 32'hFFFF_FFFF));
      add(mk(SIDE_OLDER, 1'b0, 64'h8000_0000_0000_0000, 64'h9AFF_FFFF_FFFF_FFFF,
             5'd16, 32'h8000_0000));

      // Sorted list of distinct keys, each placed in one run or in both.
      while (key_list.size() < RUN_KEYS) begin
         rk.it  = make_key();
         rk.ord = merge_order(rk.it);
         pos = 0;
         while (pos < key_list.size() && key_list[pos].ord < rk.ord) pos++;
         if (pos == key_list.size() || key_list[pos].ord != rk.ord)
            key_list.insert(pos, rk);
      end
      foreach (key_list[i]) begin
         it = key_list[i].it;
         it.is_end = 1'b0;
         pos = $urandom_range(99);
         if (pos < 35 || pos >= 70) begin
            it.side = SIDE_OLDER;
            it.ppa  = pick_ppa();
            older_run.push_back(it);
         end
         if (pos >= 35) begin
            it.side = SIDE_NEWER;
            it.ppa  = pick_ppa();
            newer_run.push_back(it);
         end
      end

      // Feed mostly the side asked for; sometimes the other one, which is
      // either taken early or dropped as a stray beat.
      oi = 0;
      ni = 0;
      while (!(plan_heads.o_drained && plan_heads.n_drained)) begin
         s = (plan_need == NEED_NEWER);
         if ($urandom_range(99) < 15) s = ~s;
         open = s ? (!plan_heads.n_valid && !plan_heads.n_drained)
                  : (!plan_heads.o_valid && !plan_heads.o_drained);
         if (open && !s && oi < older_run.size()) begin
            add(older_run[oi]);
            oi++;
         end else if (open && s && ni < newer_run.size()) begin
            add(newer_run[ni]);
            ni++;
         end else begin
            // End mark once a run is used up, else a stray beat; key is junk.
            nz = random_item();
            nz.side = s;
            if (open) nz.is_end = 1'b1;
            add(nz);
         end
      end
      // After completion every beat is only acknowledged.
      for (pos = 0; pos < TAIL_BEATS; pos++) add(random_item());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      total = script_q.size();
      for (ph = 0; ph < 4; ph++) begin
         @(negedge clock);
         send_idle_pct  = idle_tab[ph];
         recv_stall_pct = stall_tab[ph];
         for (pos = ph * total / 4; pos < (ph + 1) * total / 4; pos++)
            entry_q.push_back(script_q[pos]);
         // Hold the sender until every owed result has come back.
         while (entry_q.size() != 0 || req_tvalid || due_q.size() != 0)
            @(negedge clock);
      end

      // Give a stray late beat the time to show up.
      repeat (8) @(negedge clock);
      if (due_q.size() != 0)
         report($sformatf("%0d results never arrived", due_q.size()));

      $display("tb: %0d request beats over 4 idle/stall mixes, both runs drained",
               n_req);
      $display("tb: seen %0d entries, %0d invalidations, %0d completions, %0d acks",
               n_entry, n_inval, n_done, n_ack);
      if (n_err == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
